// ===== src/ebhc_pkg.sv =====
// Shared types, constants and CRC-32 helper for the record header checker.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package ebhc_pkg;

  // Header layout, in byte positions from the start of the record
  localparam int unsigned MagicEnd   = 4;
  localparam int unsigned VersionEnd = 6;
  localparam int unsigned LengthEnd  = 8;
  localparam int unsigned SeqStart   = 12;
  localparam int unsigned SeqBytes   = 4;
  localparam int unsigned HdrBytes   = SeqStart + SeqBytes;

  // Byte counter width and its saturation value
  localparam int unsigned CountW = 17;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  // Configuration port
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAGIC_VALUE    = 8'd0,
    CFG_FORMAT_VERSION = 8'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_SHORT    = 3'd1,
    ERR_MAGIC    = 3'd2,
    ERR_VERSION  = 3'd3,
    ERR_OVERRUN  = 3'd4,
    ERR_CRC      = 3'd5
  } err_code_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic        valid_res;
    logic [2:0]  error_code;
    logic [31:0] seq_number;
    logic [15:0] payload_length;
  } out_beat_t;

  typedef struct packed {
    logic [31:0] magic_value;
    logic [15:0] format_version;
  } cfg_t;

  // Reflected CRC-32 update over one byte
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== src/env_block_header_crc_check_core.sv =====
// Top level of the record header checker: input register, record core, result register.
// Depends on ebhc_pkg, ebhc_cfg_regs, ebhc_record and ebhc_out_reg.
`timescale 1ns / 1ps

// Checks stored records streamed one byte per beat: a 16-byte big-endian header
// (magic, version, payload length, CRC-32, sequence number) then the payload; the
// beat with last set closes the record and yields one result beat. The block takes
// one byte every clock cycle; a result beat shows on the output once its final byte,
// accepted into the input register, has advanced into the result register. The input
// register feeds one byte-wide CRC-32 update and the header checks, which land in the
// result register; input stalls only when a final byte waits on a result register
// that is still full and stalled. Write the expected magic and version only while no
// record is in flight.
module env_block_header_crc_check_core import ebhc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_beat_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_beat_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t      cfg;
  out_beat_t res;
  logic      out_free;
  logic      s1_valid_q, s1_valid_d;
  in_beat_t  s1_data_q;
  logic      s1_adv;
  logic      in_accept;

  ebhc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Advance the held byte unless its result has nowhere to go
  assign s1_adv     = s1_valid_q && (!s1_data_q.last || out_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_accept || (s1_valid_q && !s1_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_data_q <= in_data_i;
    end
  end

  ebhc_record u_record (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (s1_adv),
    .beat_i (s1_data_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  ebhc_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_adv && s1_data_q.last),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTH
  a_stall_needs_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s1_data_q.last && out_valid_o && out_stall_i)
    else $error("input stalled without a blocked final byte");
  a_last_makes_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_data_q.last |=> out_valid_o)
    else $error("final byte advanced without a result beat");
  a_ok_has_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.valid_res == (out_data_o.error_code == ERR_OK))
    else $error("result valid flag disagrees with error code");
`endif

endmodule

// ===== src/ebhc_cfg_regs.sv =====
// Configuration registers of the record header checker: expected magic and version.
// Depends on ebhc_pkg for the register index codes and the cfg_t struct.
`timescale 1ns / 1ps

module ebhc_cfg_regs import ebhc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  // Decode the write beat; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_MAGIC_VALUE) begin
        cfg_d.magic_value = cfg_data_i[31:0];
      end else if (cfg_index_i == CFG_FORMAT_VERSION) begin
        cfg_d.format_version = cfg_data_i[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_value    <= 32'd0;
      cfg_q.format_version <= 16'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/ebhc_record.sv =====
// Record state of the header checker: header capture, running CRC, byte count
// and the final checks. Depends on ebhc_pkg.
`timescale 1ns / 1ps

module ebhc_record import ebhc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,
  input  in_beat_t  beat_i,
  input  cfg_t      cfg_i,
  output out_beat_t res_o
);

  logic [CountW-1:0] count_q, count_d;
  logic [31:0]       magic_q, magic_d;
  logic [15:0]       version_q, version_d;
  logic [15:0]       length_q, length_d;
  logic [31:0]       stored_crc_q, stored_crc_d;
  logic [31:0]       seq_q, seq_d;
  logic [31:0]       crc_q, crc_d;
  logic [CountW-1:0] crc_end;
  err_code_e         code;

  assign crc_end = CountW'(HdrBytes) + {1'b0, length_q};

  // Capture header fields; advance the CRC on bytes from the sequence number to the payload end
  always_comb begin
    magic_d      = magic_q;
    version_d    = version_q;
    length_d     = length_q;
    stored_crc_d = stored_crc_q;
    seq_d        = seq_q;
    crc_d        = crc_q;
    if (count_q < CountW'(MagicEnd)) begin
      magic_d = {magic_q[23:0], beat_i.data_byte};
    end else if (count_q < CountW'(VersionEnd)) begin
      version_d = {version_q[7:0], beat_i.data_byte};
    end else if (count_q < CountW'(LengthEnd)) begin
      length_d = {length_q[7:0], beat_i.data_byte};
    end else if (count_q < CountW'(SeqStart)) begin
      stored_crc_d = {stored_crc_q[23:0], beat_i.data_byte};
    end else if (count_q < CountW'(HdrBytes)) begin
      seq_d = {seq_q[23:0], beat_i.data_byte};
    end
    if (count_q >= CountW'(SeqStart) && count_q < crc_end) begin
      crc_d = crc32_byte(crc_q, beat_i.data_byte);
    end
    count_d = (count_q != CountMax) ? count_q + 1'b1 : count_q;
  end

  // Apply the checks in priority order
  always_comb begin
    priority if (count_d < CountW'(HdrBytes)) begin
      code = ERR_SHORT;
    end else if (magic_d != cfg_i.magic_value) begin
      code = ERR_MAGIC;
    end else if (version_d != cfg_i.format_version) begin
      code = ERR_VERSION;
    end else if (CountW'(HdrBytes) + {1'b0, length_d} > count_d) begin
      code = ERR_OVERRUN;
    end else if (~crc_d != stored_crc_d) begin
      code = ERR_CRC;
    end else begin
      code = ERR_OK;
    end
  end

  always_comb begin
    res_o.valid_res      = (code == ERR_OK);
    res_o.error_code     = code;
    res_o.seq_number     = (code == ERR_OK) ? seq_d : 32'd0;
    res_o.payload_length = (code == ERR_OK) ? length_d : 16'd0;
  end

  // Update on each advancing byte; clear after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      magic_q      <= '0;
      version_q    <= '0;
      length_q     <= '0;
      stored_crc_q <= '0;
      seq_q        <= '0;
      crc_q        <= CrcInit;
    end else if (adv_i) begin
      if (beat_i.last) begin
        count_q      <= '0;
        magic_q      <= '0;
        version_q    <= '0;
        length_q     <= '0;
        stored_crc_q <= '0;
        seq_q        <= '0;
        crc_q        <= CrcInit;
      end else begin
        count_q      <= count_d;
        magic_q      <= magic_d;
        version_q    <= version_d;
        length_q     <= length_d;
        stored_crc_q <= stored_crc_d;
        seq_q        <= seq_d;
        crc_q        <= crc_d;
      end
    end
  end

`ifndef SYNTH
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && beat_i.last |=> count_q == '0 && crc_q == CrcInit)
    else $error("record state not cleared after final byte");
  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(count_q) && $stable(crc_q) && $stable(seq_q))
    else $error("record state moved without an advancing byte");
  a_crc_idle_in_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && !beat_i.last && count_q < CountW'(SeqStart) |=> crc_q == $past(crc_q))
    else $error("CRC advanced on a header byte outside its coverage");
`endif

endmodule

// ===== src/ebhc_out_reg.sv =====
// Result register of the header checker, parting the core from the result channel.
// Depends on ebhc_pkg for the out_beat_t struct.
`timescale 1ns / 1ps

module ebhc_out_reg import ebhc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  out_beat_t res_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  logic      valid_q, valid_d;
  out_beat_t data_q;

  // Free when empty or when the held beat leaves this cycle
  assign free_o  = !valid_q || !out_stall_i;
  assign valid_d = load_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload loads without reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
